@@ rtl/core/polygon_area_perimeter_unit_assert.svh @@
// Assertion macros for the polygon area and perimeter unit.
// Each macro takes a label, an antecedent and a consequent and assumes
// that clk and rst_n are visible where it is used.
`ifndef POLYGON_AREA_PERIMETER_UNIT_ASSERT_SVH
`define POLYGON_AREA_PERIMETER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PAP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon unit check failed in the same cycle");
`define PAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon unit check failed in the next cycle");
`else
`define PAP_ASSERT_SAME(label, ante, cons)
`define PAP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/pap_pkg.sv @@
package pap_pkg;

    localparam int MAX_VERTICES = 1024;

    localparam int COORD_W  = 16;
    localparam int OPND_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int COUNT_W  = 11;
    localparam int CROSS_W  = 45;
    localparam int AREA_W   = 44;
    localparam int LEN_W    = 35;
    localparam int STATUS_W = 2;

    // Squared edge length and its Q8 root: the radicand is shifted by 16
    // so that the integer root carries eight fraction bits.
    localparam int RAD_W      = PROD_W;
    localparam int FRAC_SHIFT = 16;
    localparam int RADX_W     = RAD_W + FRAC_SHIFT;
    localparam int ROOT_W     = RADX_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ITER_W     = $clog2(ROOT_W);

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

endpackage

@@ rtl/core/pap_isqrt.sv @@
module pap_isqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pap_pkg::RAD_W-1:0]   radicand,
    output logic                        done,
    output logic [pap_pkg::ROOT_W-1:0]  root
);
    import pap_pkg::*;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ROOT_W - 1);

    logic [RADX_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    // One result bit per cycle: bring down two radicand bits, try 4r+1.
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RADX_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = {radicand, {FRAC_SHIFT{1'b0}}};
            rem_next  = '0;
            root_next = '0;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RADX_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST_ITER)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/polygon_area_perimeter_unit.sv @@
// Polygon area and perimeter unit, one vertex per transfer.
// A vertex after the first passes through the multiply states MUL0..MUL4 on the shared
// 17x17 multiplier and then through the one-bit-per-cycle square root unit.
// A final vertex after the first also closes the polygon with an edge back to
// the first vertex before its result is registered. rst_n is asynchronous and
// active low; it clears the sequencer, the vertex count, both sums and out_valid.
`include "polygon_area_perimeter_unit_assert.svh"

module polygon_area_perimeter_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pap_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [pap_pkg::COORD_W-1:0]    y_coord,
    input  logic                                  last_vertex,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pap_pkg::AREA_W-1:0]            area_doubled,
    output logic [pap_pkg::LEN_W-1:0]             perimeter_q8,
    output logic [pap_pkg::STATUS_W-1:0]          status
);
    import pap_pkg::*;

    // Sequencer states. The edge from vertex A to vertex B is worked through
    // MUL0..MUL4 on the shared multiplier, then SQRT waits for the root.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_MUL3 = 4'd4;
    localparam logic [3:0] S_MUL4 = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_VERTICES + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_VERTICES);
    localparam logic [COUNT_W-1:0] COUNT_MIN = COUNT_W'(3);

    logic [3:0] state_reg, state_next;

    logic signed [COORD_W-1:0] first_x_reg, first_x_next;
    logic signed [COORD_W-1:0] first_y_reg, first_y_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_W-1:0] prev_y_reg, prev_y_next;
    logic signed [COORD_W-1:0] ax_reg, ax_next;
    logic signed [COORD_W-1:0] ay_reg, ay_next;
    logic signed [COORD_W-1:0] bx_reg, bx_next;
    logic signed [COORD_W-1:0] by_reg, by_next;
    logic                      last_reg, last_next;
    logic                      closing_reg, closing_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [CROSS_W-1:0]        cross_reg, cross_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic signed [PROD_W-1:0]  mul_reg;
    logic [RAD_W-1:0]          rad_reg, rad_next;

    logic                      out_valid_reg, out_valid_next;
    logic [AREA_W-1:0]         area_reg, area_next;
    logic [LEN_W-1:0]          perim_reg, perim_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    logic signed [OPND_W-1:0]  dx;
    logic signed [OPND_W-1:0]  dy;
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic [CROSS_W-1:0]        mul_ext;
    logic [CROSS_W-1:0]        cross_abs;

    logic                      in_xfer;
    logic                      out_free;
    logic                      sq_start;
    logic                      sq_done;
    logic [ROOT_W-1:0]         sq_root;

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign sq_start = (state_reg == S_MUL4);

    // Edge deltas, one bit wider than the coordinates so they never wrap.
    assign dx = OPND_W'(bx_reg) - OPND_W'(ax_reg);
    assign dy = OPND_W'(by_reg) - OPND_W'(ay_reg);

    // Shared multiplier: cross terms first, then the squared deltas.
    always_comb
    begin
        unique case (state_reg)
            S_MUL0:
            begin
                mul_a = OPND_W'(ax_reg);
                mul_b = OPND_W'(by_reg);
            end
            S_MUL1:
            begin
                mul_a = OPND_W'(bx_reg);
                mul_b = OPND_W'(ay_reg);
            end
            S_MUL2:
            begin
                mul_a = dx;
                mul_b = dx;
            end
            default:
            begin
                mul_a = dy;
                mul_b = dy;
            end
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mul_ext  = CROSS_W'(mul_reg);

    // Twice the area is the magnitude of the two's complement shoelace sum.
    assign cross_abs = cross_reg[CROSS_W-1] ? (~cross_reg + 1'b1) : cross_reg;

    pap_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rad_reg + RAD_W'(mul_reg)),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next     = state_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        last_next      = last_reg;
        closing_next   = closing_reg;
        count_next     = count_reg;
        cross_next     = cross_reg;
        len_next       = len_reg;
        rad_next       = rad_reg;
        out_valid_next = out_valid_reg && !out_ready;
        area_next      = area_reg;
        perim_next     = perim_reg;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next   = last_vertex;
                    prev_x_next = x_coord;
                    prev_y_next = y_coord;
                    if (count_reg != COUNT_SAT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (count_reg == '0)
                    begin
                        // The first vertex opens no edge. A lone vertex that is
                        // also the last closes onto itself, adding nothing.
                        first_x_next = x_coord;
                        first_y_next = y_coord;
                        if (last_vertex)
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        ax_next      = prev_x_reg;
                        ay_next      = prev_y_reg;
                        bx_next      = x_coord;
                        by_next      = y_coord;
                        closing_next = 1'b0;
                        state_next   = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cross_next = cross_reg + mul_ext;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cross_next = cross_reg - mul_ext;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                rad_next   = RAD_W'(mul_reg);
                state_next = S_MUL4;
            end
            S_MUL4:
            begin
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_done)
                begin
                    len_next = len_reg + LEN_W'(sq_root);
                    if (closing_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else if (last_reg)
                    begin
                        // Close the polygon from this vertex back to the first.
                        ax_next      = bx_reg;
                        ay_next      = by_reg;
                        bx_next      = first_x_reg;
                        by_next      = first_y_reg;
                        closing_next = 1'b1;
                        state_next   = S_MUL0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg < COUNT_MIN)
                    begin
                        status_next = STATUS_TOO_FEW;
                        area_next   = '0;
                        perim_next  = '0;
                    end
                    else if (count_reg > COUNT_MAX)
                    begin
                        status_next = STATUS_TOO_MANY;
                        area_next   = '0;
                        perim_next  = '0;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        area_next   = cross_abs[AREA_W-1:0];
                        perim_next  = len_reg;
                    end
                    count_next = '0;
                    cross_next = '0;
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cross_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cross_reg     <= cross_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        last_reg    <= last_next;
        closing_reg <= closing_next;
        mul_reg     <= mul_prod;
        rad_reg     <= rad_next;
        area_reg    <= area_next;
        perim_reg   <= perim_next;
        status_reg  <= status_next;
    end

    // New vertices are taken only between edges; a waiting result holds the unit only in S_OUT.
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign area_doubled = area_reg;
    assign perimeter_q8 = perim_reg;
    assign status       = status_reg;

    // A first vertex that does not end the polygon needs no arithmetic.
    `PAP_ASSERT_NEXT(a_first_vertex_quick, in_xfer && count_reg == '0 && !last_vertex, in_ready)
    // The root unit only reports back while the sequencer waits for it.
    `PAP_ASSERT_SAME(a_sqrt_done_in_wait, sq_done, state_reg == S_SQRT)
    // A polygon is only closed after at least one vertex was counted.
    `PAP_ASSERT_SAME(a_out_has_vertices, state_reg == S_OUT, count_reg != '0)
    // Error results carry no area and no perimeter.
    `PAP_ASSERT_SAME(a_error_fields_zero, out_valid && status != STATUS_OK, area_doubled == '0 && perimeter_q8 == '0)

endmodule

@@ sim/tb_top.sv @@
module tb_top;

    import pap_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the unit under test.
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [COORD_W-1:0]  x_coord = '0;
    logic signed [COORD_W-1:0]  y_coord = '0;
    logic                       last_vertex = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [AREA_W-1:0]          area_doubled;
    logic [LEN_W-1:0]           perimeter_q8;
    logic [STATUS_W-1:0]        status;

    always #5 clk = ~clk;

    polygon_area_perimeter_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .last_vertex  (last_vertex),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .area_doubled (area_doubled),
        .perimeter_q8 (perimeter_q8),
        .status       (status)
    );

    // ------------------------------------------------------------------
    // Stimulus and expectation storage.
    // ------------------------------------------------------------------
    // One queued vertex. The phase selects how often each side idles while
    // the vertex is in flight. A vertex marked drain_first is not offered
    // until every polygon result already owed has been transferred.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        int                        phase;
        bit                        drain_first;
    } vertex_item_t;

    typedef struct {
        logic [AREA_W-1:0]   area;
        logic [LEN_W-1:0]    perim;
        logic [STATUS_W-1:0] status;
    } polygon_result_t;

    vertex_item_t    vertex_q[$];
    polygon_result_t owed_results_q[$];

    // Phase 0: sender idles rarely, receiver often. Phase 1: the reverse.
    // Phase 2: neither side idles.
    int sender_idle_pct[3] = '{13, 69, 0};
    int recv_idle_pct[3]   = '{69, 13, 0};
    int cur_phase = 0;

    int  error_count = 0;
    int  vertices_sent = 0;
    int  results_checked = 0;
    int  closed_ok = 0;
    int  closed_too_few = 0;
    int  closed_too_many = 0;
    bit  vertex_taken = 1'b0;
    polygon_result_t got_want;

    // ------------------------------------------------------------------
    // Polygon predictor. It tracks the open polygon the same way the unit
    // does: first and previous vertex, a 45-bit signed shoelace sum and a
    // 35-bit Q8 perimeter sum, with a vertex count that saturates one past
    // the largest legal polygon.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] poly_first_x, poly_first_y;
    logic signed [COORD_W-1:0] poly_prev_x, poly_prev_y;
    int unsigned               poly_vertices = 0;
    logic [CROSS_W-1:0]        shoelace_acc = '0;
    logic [LEN_W-1:0]          perimeter_acc = '0;

    // Floor of the square root, built one root bit at a time from the top.
    // The radicand stays below 2**50, so a 32-bit root candidate squared
    // never overflows 64 bits.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // Adds the edge from a to b: its shoelace cross term and its length in
    // Q8, where the squared length is scaled by 2**16 before the root.
    function automatic void accumulate_edge(logic signed [COORD_W-1:0] ax,
                                            logic signed [COORD_W-1:0] ay,
                                            logic signed [COORD_W-1:0] bx,
                                            logic signed [COORD_W-1:0] by);
        longint          cross_term;
        longint          dx;
        longint          dy;
        longint unsigned len_sq;
        longint unsigned len_q8;
        cross_term = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
        dx = longint'(bx) - longint'(ax);
        dy = longint'(by) - longint'(ay);
        len_sq = longint'(dx * dx + dy * dy);
        len_q8 = floor_sqrt(len_sq << 16);
        shoelace_acc  = shoelace_acc + cross_term[CROSS_W-1:0];
        perimeter_acc = perimeter_acc + len_q8[LEN_W-1:0];
    endfunction

    // Runs one transferred vertex through the predictor. A final vertex
    // closes the polygon back to its first vertex, queues the result the
    // unit owes and clears the polygon state.
    function automatic void predict_vertex(logic signed [COORD_W-1:0] vx,
                                           logic signed [COORD_W-1:0] vy,
                                           logic                      vlast);
        polygon_result_t  res;
        logic [CROSS_W-1:0] magnitude;
        if (poly_vertices == 0)
        begin
            poly_first_x = vx;
            poly_first_y = vy;
        end
        else
        begin
            accumulate_edge(poly_prev_x, poly_prev_y, vx, vy);
        end
        poly_prev_x = vx;
        poly_prev_y = vy;
        if (poly_vertices < MAX_VERTICES + 1)
            poly_vertices++;

        if (!vlast)
            return;

        accumulate_edge(vx, vy, poly_first_x, poly_first_y);
        res.area   = '0;
        res.perim  = '0;
        if (poly_vertices < 3)
        begin
            res.status = STATUS_TOO_FEW;
            closed_too_few++;
        end
        else if (poly_vertices > MAX_VERTICES)
        begin
            res.status = STATUS_TOO_MANY;
            closed_too_many++;
        end
        else
        begin
            // A clockwise polygon leaves a negative sum; the area is its
            // magnitude, kept to the 44-bit output width.
            magnitude  = shoelace_acc[CROSS_W-1] ? -shoelace_acc : shoelace_acc;
            res.area   = magnitude[AREA_W-1:0];
            res.perim  = perimeter_acc;
            res.status = STATUS_OK;
            closed_ok++;
        end
        owed_results_q.insert(owed_results_q.size(), res);

        poly_first_x  = '0;
        poly_first_y  = '0;
        poly_prev_x   = '0;
        poly_prev_y   = '0;
        poly_vertices = 0;
        shoelace_acc  = '0;
        perimeter_acc = '0;
    endfunction

    // ------------------------------------------------------------------
    // Vertex driver. Inputs change on the falling edge; a transfer is
    // detected on the rising edge, where the predictor also runs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_vertex(x_coord, y_coord, last_vertex);
            vertex_taken = 1'b1;
            vertices_sent++;
        end
    end

    always @(negedge clk)
    begin
        // Valid is only touched when nothing is on offer or the vertex on
        // offer has just been transferred, so the payload stays put while
        // the unit holds off.
        if (rst_n && (!in_valid || vertex_taken))
        begin
            vertex_taken = 1'b0;
            if (vertex_q.size() > 0
                && !(vertex_q[0].drain_first && owed_results_q.size() > 0)
                && $urandom_range(99) >= sender_idle_pct[vertex_q[0].phase])
            begin
                x_coord     <= vertex_q[0].x;
                y_coord     <= vertex_q[0].y;
                last_vertex <= vertex_q[0].last;
                cur_phase    = vertex_q[0].phase;
                in_valid    <= 1'b1;
                void'(vertex_q.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Ready is drawn at random on the falling edge; every
    // result transfer is matched against the oldest result still owed.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results_q.size() == 0)
            begin
                $error("result transfer with none owed: area_doubled %0d, perimeter_q8 %0d, status %0d",
                       area_doubled, perimeter_q8, status);
                error_count++;
            end
            else
            begin
                got_want = owed_results_q.pop_front();
                results_checked++;
                if (area_doubled !== got_want.area)
                begin
                    $error("area_doubled: expected %0d, actual %0d", got_want.area, area_doubled);
                    error_count++;
                end
                if (perimeter_q8 !== got_want.perim)
                begin
                    $error("perimeter_q8: expected %0d, actual %0d", got_want.perim, perimeter_q8);
                    error_count++;
                end
                if (status !== got_want.status)
                begin
                    $error("status: expected %0d, actual %0d", got_want.status, status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    task automatic push_vertex(int vx, int vy, bit vlast, int phase, bit drain);
        vertex_item_t v;
        v.x           = 16'(vx);
        v.y           = 16'(vy);
        v.last        = vlast;
        v.phase       = phase;
        v.drain_first = drain;
        vertex_q.insert(vertex_q.size(), v);
    endtask

    // Coordinate styles: the full range, a small window near the origin,
    // and the values at and next to the ends of the range and around zero.
    function automatic int pick_coord(int style);
        case (style)
            0:       return int'($urandom_range(65535)) - 32768;
            1:       return int'($urandom_range(200)) - 100;
            default:
            begin
                case ($urandom_range(6))
                    0:       return -32768;
                    1:       return -32767;
                    2:       return -1;
                    3:       return 0;
                    4:       return 1;
                    5:       return 32766;
                    default: return 32767;
                endcase
            end
        endcase
    endfunction

    // Queues one polygon of the given size; the flag goes on its last vertex.
    task automatic push_polygon(int size, int phase, bit drain);
        int style;
        style = $urandom_range(2);
        for (int i = 0; i < size; i++)
            push_vertex(pick_coord(style), pick_coord(style), i == size - 1, phase,
                        drain && i == 0);
    endtask

    // Mostly ordinary polygons of three to eight vertices, some larger ones
    // and a few that are too short to close.
    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return $urandom_range(2, 1);
        else if (r < 88)
            return $urandom_range(8, 3);
        else
            return $urandom_range(40, 9);
    endfunction

    initial
    begin
        int before_cnt;

        // Directed polygons: the smallest sizes that cannot close, the
        // extreme corners of the coordinate range, a polygon collapsed to a
        // point, a clockwise winding and a collinear triangle.
        push_vertex(32767, -32768, 1, 0, 0);
        push_vertex(-32768, -32768, 0, 0, 0);
        push_vertex(32767, 32767, 1, 0, 0);
        push_vertex(-32768, -32768, 0, 0, 0);
        push_vertex(32767, -32768, 0, 0, 0);
        push_vertex(32767, 32767, 1, 0, 0);
        push_vertex(-32768, -32768, 0, 0, 0);
        push_vertex(32767, -32768, 0, 0, 0);
        push_vertex(32767, 32767, 0, 0, 0);
        push_vertex(-32768, 32767, 1, 0, 0);
        push_vertex(0, 0, 0, 0, 0);
        push_vertex(0, 0, 0, 0, 0);
        push_vertex(0, 0, 1, 0, 0);
        push_vertex(0, 0, 0, 0, 0);
        push_vertex(0, 10, 0, 0, 0);
        push_vertex(10, 0, 1, 0, 0);
        push_vertex(1, 1, 0, 0, 0);
        push_vertex(2, 2, 0, 0, 0);
        push_vertex(3, 3, 1, 0, 0);

        // Random part. A polygon past the vertex limit, long enough for the
        // count to saturate, rides along in the second phase; each phase
        // opens with a vertex that waits for every owed result to drain.
        for (int p = 0; p < 3; p++)
        begin
            before_cnt = vertex_q.size();
            while (vertex_q.size() - before_cnt < 230)
                push_polygon(pick_size(), p, vertex_q.size() == before_cnt);
            if (p == 1)
                push_polygon(MAX_VERTICES + 3, p, 1'b0);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Let every vertex go out, every owed result come back, then allow
        // the unit's closing latency for any stray result to show up.
        while (vertex_q.size() != 0 || in_valid)
            @(posedge clk);
        while (owed_results_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d vertices across three handshake pacing phases; checked %0d results.",
                 vertices_sent, results_checked);
        $display("Polygons closed: %0d normal, %0d with too few vertices, %0d with too many.",
                 closed_ok, closed_too_few, closed_too_many);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run at the heaviest pacing.
    initial
    begin
        #12000000;
        $display("FAIL");
        $finish;
    end

endmodule
